/* sv/spq_pkg.sv */
// Package with the word types, opcodes and sequencer states of the event queue.
package spq_pkg;

  localparam logic [15:0] PRIO_MASK = 16'hFF00;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_PUSH_WR,
    ST_POP_RD,
    ST_POP_DATA,
    ST_FIN
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] event_status;
    logic [7:0]  system_tag;
    logic [7:0]  resource_tag;
  } in_word_t;

  typedef struct packed {
    logic        popped;
    logic [15:0] out_status;
    logic [7:0]  out_system;
    logic [7:0]  out_resource;
    logic        dropped_full;
    logic [4:0]  occupancy;
  } out_word_t;

endpackage

/* sv/stable_priority_event_queue_top.sv */
// Top level of the stable priority event queue with its output register.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid_i/in_stall_o   | spq_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i | spq_pkg::out_word_t
//
// A push runs a tail-to-head scan to find its slot; the scan shares one memory
// read port and one priority compare. A pop reads the head entry, and a dropped
// push or a pop of an empty queue goes straight to the result.
// Reset empties the queue at once; entry storage is not cleared.
// A stalled result holds in the output register while the next word is taken.
module stable_priority_event_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_word_t out_word_o
);
  import spq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EW = 16 + 2 * TAG_BITS;

  logic          busy;
  logic          fin_valid, fin_take;
  out_word_t     fin_word;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic          out_valid_q;
  out_word_t     out_word_q;

  assign in_stall_o = busy;
  assign fin_take   = fin_valid && (!out_valid_q || !out_stall_i);

  spq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_valid_i && !busy),
    .in_word_i  (in_word_i),
    .busy_o     (busy),
    .fin_take_i (fin_take),
    .fin_valid_o(fin_valid),
    .fin_word_o (fin_word),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  spq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW),
    .W    (EW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      out_word_q <= fin_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* sv/spq_mem.sv */
// Entry memory of the event queue with one write port and one registered read port.
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/spq_ctrl.sv */
// Sequencer of the event queue: ring pointers, insertion scan and the priority compare unit.
module spq_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 8,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int EW = 16 + 2 * TAG_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  spq_pkg::in_word_t in_word_i,
  output logic              busy_o,
  input  logic              fin_take_i,
  output logic              fin_valid_o,
  output spq_pkg::out_word_t fin_word_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [EW-1:0]     mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [EW-1:0]     mem_rdata_i
);
  import spq_pkg::*;

  localparam int SW = CW + 1;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [15:0]         new_status_q, new_status_d;
  logic [TAG_BITS-1:0] new_sys_q, new_sys_d;
  logic [TAG_BITS-1:0] new_res_q, new_res_d;
  out_word_t           res_q, res_d;

  logic [SW-1:0]       rd_sum, wr_sum;
  logic [AW-1:0]       rd_phys, wr_phys, head_inc;
  logic [15:0]         rd_status;
  logic [TAG_BITS-1:0] rd_sys, rd_res;
  logic                shift;
  logic [TAG_BITS+7:0] in_sys_ext, in_res_ext;

  function automatic logic [4:0] occ_f(input logic [CW-1:0] c);
    logic [CW+4:0] e;
    e = {5'b0, c};
    return e[4:0];
  endfunction

  function automatic logic [7:0] tag_out_f(input logic [TAG_BITS-1:0] t);
    logic [TAG_BITS+7:0] e;
    e = {8'b0, t};
    return e[7:0];
  endfunction

  assign rd_status  = mem_rdata_i[EW-1 -: 16];
  assign rd_sys     = mem_rdata_i[2*TAG_BITS-1 -: TAG_BITS];
  assign rd_res     = mem_rdata_i[TAG_BITS-1:0];
  assign shift      = (rd_status & PRIO_MASK) < (new_status_q & PRIO_MASK);
  assign in_sys_ext = {{TAG_BITS{1'b0}}, in_word_i.system_tag};
  assign in_res_ext = {{TAG_BITS{1'b0}}, in_word_i.resource_tag};
  assign head_inc   = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);

  always_comb begin
    rd_sum = SW'(head_q) + SW'(idx_q) - SW'(1);
    if (rd_sum >= SW'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - SW'(QUEUE_DEPTH);
    end
    wr_sum = SW'(head_q) + SW'(idx_q);
    if (wr_sum >= SW'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SW'(QUEUE_DEPTH);
    end
    rd_phys = rd_sum[AW-1:0];
    wr_phys = wr_sum[AW-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          if (in_word_i.opcode == OP_PUSH) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              state_d = ST_FIN;
            end else if (count_q == '0) begin
              state_d = ST_PUSH_WR;
            end else begin
              state_d = ST_PUSH_RD;
            end
          end else begin
            state_d = (count_q == '0) ? ST_FIN : ST_POP_RD;
          end
        end
      end
      ST_PUSH_RD:  state_d = ST_PUSH_CMP;
      ST_PUSH_CMP: begin
        if (shift && (idx_q != CW'(1))) begin
          state_d = ST_PUSH_RD;
        end else begin
          state_d = ST_PUSH_WR;
        end
      end
      ST_PUSH_WR:  state_d = ST_FIN;
      ST_POP_RD:   state_d = ST_POP_DATA;
      ST_POP_DATA: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    new_status_d = new_status_q;
    new_sys_d    = new_sys_q;
    new_res_d    = new_res_q;
    res_d        = res_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = wr_phys;
    mem_wdata_o  = {new_status_q, new_sys_q, new_res_q};
    mem_raddr_o  = rd_phys;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          new_status_d = in_word_i.event_status;
          new_sys_d    = in_sys_ext[TAG_BITS-1:0];
          new_res_d    = in_res_ext[TAG_BITS-1:0];
          idx_d        = count_q;
          res_d        = '0;
          res_d.occupancy = occ_f(count_q);
          if ((in_word_i.opcode == OP_PUSH) && (count_q == CW'(QUEUE_DEPTH))) begin
            res_d.dropped_full = 1'b1;
          end
        end
      end
      ST_PUSH_CMP: begin
        if (shift) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - CW'(1);
        end
      end
      ST_PUSH_WR: begin
        mem_we_o        = 1'b1;
        count_d         = count_q + CW'(1);
        res_d           = '0;
        res_d.occupancy = occ_f(count_q + CW'(1));
      end
      ST_POP_RD: begin
        mem_raddr_o = head_q;
      end
      ST_POP_DATA: begin
        head_d             = head_inc;
        count_d            = count_q - CW'(1);
        res_d              = '0;
        res_d.popped       = 1'b1;
        res_d.out_status   = rd_status;
        res_d.out_system   = tag_out_f(rd_sys);
        res_d.out_resource = tag_out_f(rd_res);
        res_d.occupancy    = occ_f(count_q - CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_status_q <= new_status_d;
    new_sys_q    <= new_sys_d;
    new_res_q    <= new_res_d;
    res_q        <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign fin_valid_o = (state_q == ST_FIN);
  assign fin_word_o  = res_q;

endmodule

/* sv/spq_checker.sv */
// Port checker of the event queue and its bind to the top level.
module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input spq_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input spq_pkg::out_word_t out_word_o
);
  import spq_pkg::*;

  logic unused_in;
  assign unused_in = ^in_word_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("Stalled result word changed or vanished.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again in the cycle after a word was accepted.");

  a_pop_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.popped && out_word_o.dropped_full))
    else $error("Result word reports both a pop and a dropped push.");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.occupancy <= QUEUE_DEPTH) &&
                    (out_word_o.dropped_full ? (out_word_o.occupancy == QUEUE_DEPTH) : 1'b1))
    else $error("Result word reports an impossible occupancy.");

endmodule

bind stable_priority_event_queue_top spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the stable priority event queue, with a scoreboard that predicts each result word.
import spq_pkg::*;

class event_queue_predictor #(int DEPTH = 16);
  typedef struct packed {
    logic [15:0] status;
    logic [7:0]  system;
    logic [7:0]  resource;
  } held_event_t;

  held_event_t slots[DEPTH];
  int          held;
  out_word_t   awaited_words[$];
  int          mismatches;
  int          words_checked;
  int          pushes;
  int          drops;
  int          pops;
  int          empty_pops;
  int          peak_held;

  function new();
    held          = 0;
    mismatches    = 0;
    words_checked = 0;
    pushes        = 0;
    drops         = 0;
    pops          = 0;
    empty_pops    = 0;
    peak_held     = 0;
  endfunction

  function void note_word(in_word_t w);
    out_word_t r;
    int        pos;
    int        i;
    r = '0;
    if (w.opcode == OP_PUSH) begin
      pushes++;
      if (held == DEPTH) begin
        r.dropped_full = 1'b1;
        drops++;
      end else begin
        pos = 0;
        while (pos < held &&
               (slots[pos].status & PRIO_MASK) >= (w.event_status & PRIO_MASK))
          pos++;
        for (i = held; i > pos; i--) slots[i] = slots[i - 1];
        slots[pos] = '{w.event_status, w.system_tag, w.resource_tag};
        held++;
      end
    end else begin
      pops++;
      if (held == 0) begin
        empty_pops++;
      end else begin
        r.popped       = 1'b1;
        r.out_status   = slots[0].status;
        r.out_system   = slots[0].system;
        r.out_resource = slots[0].resource;
        for (i = 1; i < held; i++) slots[i - 1] = slots[i];
        held--;
      end
    end
    if (held > peak_held) peak_held = held;
    r.occupancy = 5'(held);
    awaited_words.push_back(r);
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %s", msg);
  endfunction

  function void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got)
      report($sformatf("word %0d, %s: expected 0x%0h, got 0x%0h",
                       words_checked, field, want, got));
  endfunction

  function void check_word(out_word_t got);
    out_word_t want;
    words_checked++;
    if (awaited_words.size() == 0) begin
      report($sformatf("word %0d arrived with no result awaited: 0x%0h", words_checked, got));
      return;
    end
    want = awaited_words.pop_front();
    check_field("popped", want.popped, got.popped);
    check_field("out_status", want.out_status, got.out_status);
    check_field("out_system", want.out_system, got.out_system);
    check_field("out_resource", want.out_resource, got.out_resource);
    check_field("dropped_full", want.dropped_full, got.dropped_full);
    check_field("occupancy", want.occupancy, got.occupancy);
  endfunction
endclass

module tb_top;
  localparam int QUEUE_SLOTS = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [15:0] DIRECTED_STATUS [16] = '{
    16'hFFFF, 16'h0000, 16'hFF00, 16'h00FF, 16'h8001, 16'h8002, 16'h0001, 16'h7FFF,
    16'h8003, 16'hFF01, 16'h0102, 16'h0103, 16'h0100, 16'h8000, 16'hFFFE, 16'h0000
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;

  event_queue_predictor #(QUEUE_SLOTS) predictor;

  stable_priority_event_queue_top #(
    .QUEUE_DEPTH(QUEUE_SLOTS),
    .TAG_BITS   (8)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) predictor.check_word(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Run stopped: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic in_word_t make_push(logic [15:0] status, logic [7:0] sys, logic [7:0] res);
    in_word_t w;
    w.opcode       = OP_PUSH;
    w.event_status = status;
    w.system_tag   = sys;
    w.resource_tag = res;
    return w;
  endfunction

  function automatic in_word_t random_word(int push_pct);
    in_word_t   w;
    logic [7:0] prio;
    case ($urandom_range(3))
      0:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
      1:       prio = 8'h40 + 8'($urandom_range(2));
      default: prio = 8'($urandom);
    endcase
    w.opcode       = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    w.event_status = {prio, 8'($urandom)};
    w.system_tag   = 8'($urandom);
    w.resource_tag = 8'($urandom);
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predictor.note_word(w);
  endtask

  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predictor.awaited_words.size() != 0);
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall, int n);
    int sent;
    int burst;
    int push_pct;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    sent      = 0;
    while (sent < n) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(3))
        0:       push_pct = 85;
        1:       push_pct = 20;
        2:       push_pct = 50;
        default: push_pct = 65;
      endcase
      repeat (burst) begin
        send_word(random_word(push_pct));
        sent++;
      end
    end
    idle_until_drained();
  endtask

  initial begin : stimulus
    int i;
    predictor = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(random_word(0));
    for (i = 0; i < QUEUE_SLOTS; i++)
      send_word(make_push(DIRECTED_STATUS[i], 8'(i * 17), ~8'(i * 17)));
    send_word(make_push(16'h1234, 8'h5A, 8'hA5));
    repeat (4) send_word(random_word(0));
    send_word(make_push(16'hFF00, 8'h3C, 8'hC3));
    idle_until_drained();

    run_phase(0, 0, 440);
    run_phase(48, 0, 430);
    run_phase(0, 48, 430);
    run_phase(17, 17, 430);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d words: %0d pushes (%0d dropped on a full queue), %0d pops (%0d empty).",
             predictor.pushes + predictor.pops, predictor.pushes, predictor.drops,
             predictor.pops, predictor.empty_pops);
    $display("Peak occupancy %0d of %0d; %0d result words checked under four idle/stall mixes.",
             predictor.peak_held, QUEUE_SLOTS, predictor.words_checked);
    if (predictor.mismatches == 0 && predictor.awaited_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
